// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define QRS_ASSERT_HOLD(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// implication checked at the same edge
`define QRS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/qrs_pkg.sv =====
package qrs_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int THR_W       = 14;
   localparam int MAG_W       = 23;
   localparam int NORM_W      = 30;
   localparam int LEN_W       = 31;
   localparam int QUOT_W      = 16;
   localparam int REM_W       = 47;
   localparam int SQ_W        = 64;
   localparam int SQRT_STAGES = 16;
   localparam int DIV_STAGES  = 8;

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] ref_look_x;
      logic signed [15:0] ref_look_y;
      logic signed [15:0] ref_look_z;
      logic signed [15:0] ref_right_x;
      logic signed [15:0] ref_right_y;
      logic signed [15:0] ref_right_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] look_x;
      logic signed [15:0] look_y;
      logic signed [15:0] look_z;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic signed [15:0] right_z;
      logic               look_degenerate;
      logic               right_degenerate;
   } rsp_type;

   // rotated vector after snapping, as magnitude and sign
   typedef struct packed {
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
   } rot_vec_type;

   // normalized vector before the sign is applied
   typedef struct packed {
      logic                   valid;
      logic                   zero;
      logic [2:0]             neg;
      logic [2:0][QUOT_W-1:0] quot;
   } norm_res_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
   } sqrt_pair_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic             qbit;
   } div_step_type;

   function automatic logic signed [20:0] round_matrix(logic signed [35:0] x);
      logic signed [35:0] t;
      t = (x + (36'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return t[20:0];
   endfunction

   function automatic sqrt_pair_type sqrt_iter(sqrt_pair_type a, logic [SQ_W-1:0] bitv);
      sqrt_pair_type r;
      if (a.rem >= a.root + bitv) begin
         r.rem  = a.rem - (a.root + bitv);
         r.root = (a.root >> 1) + bitv;
      end else begin
         r.rem  = a.rem;
         r.root = a.root >> 1;
      end
      return r;
   endfunction

   function automatic div_step_type div_iter(logic [REM_W-1:0] rem, logic [REM_W-1:0] dsh);
      div_step_type r;
      if (rem >= dsh) begin
         r.rem  = rem - dsh;
         r.qbit = 1'b1;
      end else begin
         r.rem  = rem;
         r.qbit = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/quaternion_rotate_snap_normalize_core.sv =====
// the path from the accepting edge to the result on rsp_valid runs through 32 register stages
// throughput: one item per cycle; every stage advances together unless a result is stalled
// the depth comes from the 16-stage square root and 8-stage divider of each vector
// reset: synchronous, active high; clears all valid bits, snap threshold returns to 1
// a stall on a valid result holds the whole pipeline and raises req_stall
`include "assert_macros.svh"

module quaternion_rotate_snap_normalize_core import qrs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);

   function automatic logic signed [15:0] apply_sign(logic [QUOT_W-1:0] q, logic neg,
                                                     logic zero);
      logic signed [15:0] r;
      if (zero) r = '0;
      else if (neg) r = -$signed(q);
      else r = $signed(q);
      return r;
   endfunction

   logic             adv;
   logic [THR_W-1:0] thr_ff;
   logic             rot_valid;
   rot_vec_type      rot_look, rot_right;
   norm_res_type     look_res, right_res;
   logic             rsp_valid_ff;
   rsp_type          rsp_in, rsp_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   qrs_rotate u_rotate (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (req_valid),
      .in_data        (req_data),
      .snap_threshold (thr_ff),
      .out_valid      (rot_valid),
      .out_look       (rot_look),
      .out_right      (rot_right)
   );

   qrs_norm u_norm_look (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (rot_valid),
      .in_vec   (rot_look),
      .out_res  (look_res)
   );

   qrs_norm u_norm_right (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (rot_valid),
      .in_vec   (rot_right),
      .out_res  (right_res)
   );

   always_comb begin
      rsp_in.look_x  = apply_sign(look_res.quot[0], look_res.neg[0], look_res.zero);
      rsp_in.look_y  = apply_sign(look_res.quot[1], look_res.neg[1], look_res.zero);
      rsp_in.look_z  = apply_sign(look_res.quot[2], look_res.neg[2], look_res.zero);
      rsp_in.right_x = apply_sign(right_res.quot[0], right_res.neg[0], right_res.zero);
      rsp_in.right_y = apply_sign(right_res.quot[1], right_res.neg[1], right_res.zero);
      rsp_in.right_z = apply_sign(right_res.quot[2], right_res.neg[2], right_res.zero);
      rsp_in.look_degenerate  = look_res.zero;
      rsp_in.right_degenerate = right_res.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= look_res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // both vector pipelines must stay in lock step
   `QRS_ASSERT_HOLD(a_norm_sync, look_res.valid == right_res.valid, "norm pipelines out of step")
   `QRS_ASSERT_IMPL(a_degen_zero, rsp_valid && rsp_data.look_degenerate, rsp_data.look_x == 16'sd0 && rsp_data.look_y == 16'sd0 && rsp_data.look_z == 16'sd0, "degenerate look not zero")
   `QRS_ASSERT_IMPL(a_unit_bound, rsp_valid && !rsp_data.right_degenerate, rsp_data.right_x <= 16'sd16384 && rsp_data.right_x >= -16'sd16384, "right x beyond unit")
   `QRS_ASSERT_IMPL(a_nonzero, rsp_valid && !rsp_data.look_degenerate, rsp_data.look_x != 16'sd0 || rsp_data.look_y != 16'sd0 || rsp_data.look_z != 16'sd0, "normalized look is zero")

endmodule

// ===== hw/rtl/qrs_rotate.sv =====
module qrs_rotate import qrs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  req_type          in_data,
   input  logic [THR_W-1:0] snap_threshold,
   output logic             out_valid,
   output rot_vec_type      out_look,
   output rot_vec_type      out_right
);

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } comp_type;

   localparam logic signed [35:0] ONE = 36'sd1 <<< (2 * FRAC_BITS);

   function automatic comp_type rot_comp(logic signed [36:0] p0, logic signed [36:0] p1,
                                         logic signed [36:0] p2, logic [THR_W-1:0] thr);
      logic signed [38:0] s;
      logic signed [38:0] c;
      logic [23:0]        a;
      comp_type           r;
      s = 39'(p0) + 39'(p1) + 39'(p2);
      c = (s + (39'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      r.neg = c[38];
      a = c[38] ? 24'(-c) : 24'(c);
      r.mag = (a < 24'(thr)) ? '0 : a[MAG_W-1:0];
      return r;
   endfunction

   // stage 1: quaternion products
   logic               vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic signed [31:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [15:0] lv1_ff [0:2];
   logic signed [15:0] rv1_ff [0:2];

   // stage 2: matrix
   logic signed [20:0] m_in  [0:8];
   logic signed [20:0] m_ff  [0:8];
   logic signed [15:0] lv2_ff [0:2];
   logic signed [15:0] rv2_ff [0:2];

   // stage 3: partial products
   logic signed [36:0] pl_ff [0:2][0:2];
   logic signed [36:0] pr_ff [0:2][0:2];

   // stage 4
   rot_vec_type look_in, right_in, look_ff, right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff <= in_data.quat_x * in_data.quat_x;
         yy_ff <= in_data.quat_y * in_data.quat_y;
         zz_ff <= in_data.quat_z * in_data.quat_z;
         xy_ff <= in_data.quat_x * in_data.quat_y;
         xz_ff <= in_data.quat_x * in_data.quat_z;
         yz_ff <= in_data.quat_y * in_data.quat_z;
         wx_ff <= in_data.quat_w * in_data.quat_x;
         wy_ff <= in_data.quat_w * in_data.quat_y;
         wz_ff <= in_data.quat_w * in_data.quat_z;
         lv1_ff[0] <= in_data.ref_look_x;
         lv1_ff[1] <= in_data.ref_look_y;
         lv1_ff[2] <= in_data.ref_look_z;
         rv1_ff[0] <= in_data.ref_right_x;
         rv1_ff[1] <= in_data.ref_right_y;
         rv1_ff[2] <= in_data.ref_right_z;
      end
   end

   always_comb begin
      m_in[0] = round_matrix(ONE - ((36'(yy_ff) + 36'(zz_ff)) <<< 1));
      m_in[1] = round_matrix((36'(xy_ff) - 36'(wz_ff)) <<< 1);
      m_in[2] = round_matrix((36'(xz_ff) + 36'(wy_ff)) <<< 1);
      m_in[3] = round_matrix((36'(xy_ff) + 36'(wz_ff)) <<< 1);
      m_in[4] = round_matrix(ONE - ((36'(xx_ff) + 36'(zz_ff)) <<< 1));
      m_in[5] = round_matrix((36'(yz_ff) - 36'(wx_ff)) <<< 1);
      m_in[6] = round_matrix((36'(xz_ff) - 36'(wy_ff)) <<< 1);
      m_in[7] = round_matrix((36'(yz_ff) + 36'(wx_ff)) <<< 1);
      m_in[8] = round_matrix(ONE - ((36'(xx_ff) + 36'(yy_ff)) <<< 1));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 9; i++) begin
            m_ff[i] <= m_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            lv2_ff[i] <= lv1_ff[i];
            rv2_ff[i] <= rv1_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pl_ff[i][j] <= 37'(m_ff[i*3+j]) * 37'(lv2_ff[j]);
               pr_ff[i][j] <= 37'(m_ff[i*3+j]) * 37'(rv2_ff[j]);
            end
         end
      end
   end

   always_comb begin
      comp_type cl, cr;
      look_in  = '0;
      right_in = '0;
      for (int i = 0; i < 3; i++) begin
         cl = rot_comp(pl_ff[i][0], pl_ff[i][1], pl_ff[i][2], snap_threshold);
         cr = rot_comp(pr_ff[i][0], pr_ff[i][1], pr_ff[i][2], snap_threshold);
         look_in.neg[i]  = cl.neg;
         look_in.mag[i]  = cl.mag;
         right_in.neg[i] = cr.neg;
         right_in.mag[i] = cr.mag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         look_ff  <= look_in;
         right_ff <= right_in;
      end
   end

   assign out_valid = vld4_ff;
   assign out_look  = look_ff;
   assign out_right = right_ff;

endmodule

// ===== hw/rtl/qrs_norm.sv =====
module qrs_norm import qrs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  logic         in_valid,
   input  rot_vec_type  in_vec,
   output norm_res_type out_res
);

   // shift that brings the largest component up to bit NORM_W-1
   function automatic logic [4:0] lead_shift(logic [NORM_W-1:0] m);
      logic [4:0]        s;
      logic [NORM_W-1:0] t;
      s = '0;
      t = m;
      if (t[NORM_W-1 -: 16] == '0) begin
         s = s + 5'd16;
         t = t << 16;
      end
      if (t[NORM_W-1 -: 8] == '0) begin
         s = s + 5'd8;
         t = t << 8;
      end
      if (t[NORM_W-1 -: 4] == '0) begin
         s = s + 5'd4;
         t = t << 4;
      end
      if (t[NORM_W-1 -: 2] == '0) begin
         s = s + 5'd2;
         t = t << 2;
      end
      if (t[NORM_W-1] == 1'b0) begin
         s = s + 5'd1;
      end
      return s;
   endfunction

   // stage n1: normalize shift
   logic [MAG_W-1:0]       mx;
   logic [4:0]             sh;
   logic                   n1_vld_ff, n1_zero_ff;
   logic [2:0]             n1_neg_ff;
   logic [2:0][NORM_W-1:0] n1_mag_ff;

   // stage n2: squares
   logic                   n2_vld_ff, n2_zero_ff;
   logic [2:0]             n2_neg_ff;
   logic [2:0][NORM_W-1:0] n2_mag_ff;
   logic [2*NORM_W-1:0]    n2_sq_ff [0:2];

   // sqrt pipeline, index 0 holds the sum of squares
   sqrt_pair_type          sp_ff [0:SQRT_STAGES];
   logic                   cv_ff [0:SQRT_STAGES];
   logic                   cz_ff [0:SQRT_STAGES];
   logic [2:0]             cn_ff [0:SQRT_STAGES];
   logic [2:0][NORM_W-1:0] cm_ff [0:SQRT_STAGES];

   // divider pipeline
   logic [LEN_W-1:0]       len0;
   logic [2:0][REM_W-1:0]  rem0;
   logic                   dv_ff [1:DIV_STAGES];
   logic                   dz_ff [1:DIV_STAGES];
   logic [2:0]             dn_ff [1:DIV_STAGES];
   logic [LEN_W-1:0]       dl_ff [1:DIV_STAGES];
   logic [2:0][REM_W-1:0]  dr_ff [1:DIV_STAGES];
   logic [2:0][QUOT_W-1:0] dq_ff [1:DIV_STAGES];

   always_comb begin
      mx = in_vec.mag[0];
      if (in_vec.mag[1] > mx) mx = in_vec.mag[1];
      if (in_vec.mag[2] > mx) mx = in_vec.mag[2];
      sh = lead_shift(NORM_W'(mx));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_vld_ff <= 1'b0;
         n2_vld_ff <= 1'b0;
         cv_ff[0]  <= 1'b0;
      end else if (adv) begin
         n1_vld_ff <= in_valid;
         n2_vld_ff <= n1_vld_ff;
         cv_ff[0]  <= n2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_zero_ff <= (mx == '0);
         n1_neg_ff  <= in_vec.neg;
         for (int i = 0; i < 3; i++) begin
            n1_mag_ff[i] <= NORM_W'(in_vec.mag[i]) << sh;
         end
         n2_zero_ff <= n1_zero_ff;
         n2_neg_ff  <= n1_neg_ff;
         n2_mag_ff  <= n1_mag_ff;
         for (int i = 0; i < 3; i++) begin
            n2_sq_ff[i] <= (2*NORM_W)'(n1_mag_ff[i]) * (2*NORM_W)'(n1_mag_ff[i]);
         end
         sp_ff[0].rem  <= SQ_W'(n2_sq_ff[0]) + SQ_W'(n2_sq_ff[1]) + SQ_W'(n2_sq_ff[2]);
         sp_ff[0].root <= '0;
         cz_ff[0] <= n2_zero_ff;
         cn_ff[0] <= n2_neg_ff;
         cm_ff[0] <= n2_mag_ff;
      end
   end

   // two root bits per stage, from the top pair of bit positions down
   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      sqrt_pair_type st_a, st_b;
      assign st_a = sqrt_iter(sp_ff[k], SQ_W'(1) << (SQ_W - 2 - 4*k));
      assign st_b = sqrt_iter(st_a, SQ_W'(1) << (SQ_W - 4 - 4*k));

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[k+1] <= cv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sp_ff[k+1] <= st_b;
            cz_ff[k+1] <= cz_ff[k];
            cn_ff[k+1] <= cn_ff[k];
            cm_ff[k+1] <= cm_ff[k];
         end
      end
   end

   // dividend is mag scaled up plus half the length, for round to nearest
   assign len0 = sp_ff[SQRT_STAGES].root[LEN_W-1:0];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem0[i] = (REM_W'(cm_ff[SQRT_STAGES][i]) << FRAC_BITS) + REM_W'(len0 >> 1);
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      logic                   s_vld, s_zero;
      logic [2:0]             s_neg;
      logic [LEN_W-1:0]       s_len;
      logic [2:0][REM_W-1:0]  s_rem, n_rem;
      logic [2:0][QUOT_W-1:0] s_quot, n_quot;

      if (k == 1) begin : g_first
         assign s_vld  = cv_ff[SQRT_STAGES];
         assign s_zero = cz_ff[SQRT_STAGES];
         assign s_neg  = cn_ff[SQRT_STAGES];
         assign s_len  = len0;
         assign s_rem  = rem0;
         assign s_quot = '0;
      end else begin : g_next
         assign s_vld  = dv_ff[k-1];
         assign s_zero = dz_ff[k-1];
         assign s_neg  = dn_ff[k-1];
         assign s_len  = dl_ff[k-1];
         assign s_rem  = dr_ff[k-1];
         assign s_quot = dq_ff[k-1];
      end

      always_comb begin
         div_step_type hi, lo;
         for (int i = 0; i < 3; i++) begin
            hi = div_iter(s_rem[i], REM_W'(s_len) << (QUOT_W - 1 - 2*(k-1)));
            lo = div_iter(hi.rem, REM_W'(s_len) << (QUOT_W - 2 - 2*(k-1)));
            n_rem[i]  = lo.rem;
            n_quot[i] = {s_quot[i][QUOT_W-3:0], hi.qbit, lo.qbit};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_ff[k] <= s_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dz_ff[k] <= s_zero;
            dn_ff[k] <= s_neg;
            dl_ff[k] <= s_len;
            dr_ff[k] <= n_rem;
            dq_ff[k] <= n_quot;
         end
      end
   end

   assign out_res.valid = dv_ff[DIV_STAGES];
   assign out_res.zero  = dz_ff[DIV_STAGES];
   assign out_res.neg   = dn_ff[DIV_STAGES];
   assign out_res.quot  = dq_ff[DIV_STAGES];

endmodule
